@@ hw/rtl/sfd_pkg.sv @@
// shared types and constants for the stuffed frame deframer
// no dependencies; imported by every module of the block
package sfd_pkg;

  localparam int SFD_MAX_PAYLOAD = 1024;
  localparam int SFD_QUEUE_DEPTH = 2;
  localparam int SFD_LEN_W       = 11;
  localparam int SFD_LEN_LIMIT   = 2047;

  // configuration register indexes
  localparam logic [1:0] CFG_START_CODE   = 2'd0;
  localparam logic [1:0] CFG_END_CODE     = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_CODE  = 2'd2;
  localparam logic [1:0] CFG_HOST_ADDRESS = 2'd3;

  // register reset values
  localparam logic [7:0] RST_START_CODE   = 8'hFC;
  localparam logic [7:0] RST_END_CODE     = 8'hFD;
  localparam logic [7:0] RST_ESCAPE_CODE  = 8'hFE;
  localparam logic [7:0] RST_HOST_ADDRESS = 8'h11;

  localparam logic [7:0]  ESC_XOR  = 8'd20;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // frame status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_CRC   = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_LONG  = 3'd5;

  // classified link byte
  typedef struct packed {
    logic       is_start;
    logic       is_end;
    logic       is_esc;
    logic       is_host;
    logic [7:0] data;
  } tok_t;

  // one result item
  typedef struct packed {
    logic                 kind;
    logic [7:0]           data;
    logic [2:0]           status;
    logic [SFD_LEN_W-1:0] length;
  } res_t;

endpackage

@@ hw/rtl/sfd_fifo.sv @@
// small register queue with full/empty flags
// depends on sfd_pkg
module sfd_fifo
  import sfd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = SFD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/sfd_class.sv @@
// front end: configuration registers and control code classification
// depends on sfd_pkg
module sfd_class
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic [7:0] rx_byte,
  output tok_t       tok
);

  logic [7:0] start_code;
  logic [7:0] end_code;
  logic [7:0] escape_code;
  logic [7:0] host_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code   <= RST_START_CODE;
      end_code     <= RST_END_CODE;
      escape_code  <= RST_ESCAPE_CODE;
      host_address <= RST_HOST_ADDRESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CODE:   start_code   <= cfg_data;
        CFG_END_CODE:     end_code     <= cfg_data;
        CFG_ESCAPE_CODE:  escape_code  <= cfg_data;
        CFG_HOST_ADDRESS: host_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tok.is_start = (rx_byte == start_code);
    tok.is_end   = (rx_byte == end_code);
    tok.is_esc   = (rx_byte == escape_code);
    tok.is_host  = (rx_byte == host_address);
    tok.data     = rx_byte;
  end

endmodule

@@ hw/rtl/sfd_parse.sv @@
// back end: frame parser, unescape, holdback, crc16 check and status
// depends on sfd_pkg
module sfd_parse
  import sfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SFD_MAX_PAYLOAD
) (
  input  logic clk,
  input  logic rst,
  input  tok_t tok,
  input  logic tok_valid,
  output logic tok_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam logic [SFD_LEN_W-1:0] LEN_CAP =
    SFD_LEN_W'((MAX_PAYLOAD > SFD_LEN_LIMIT) ? SFD_LEN_LIMIT : MAX_PAYLOAD);

  typedef enum logic [2:0] {
    M_IDLE, M_ADDR, M_BODY, M_ESC, M_DROP
  } mode_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  mode_t                mode, mode_next;
  logic [15:0]          crc, crc_next;
  logic [7:0]           hb0, hb0_next;
  logic [7:0]           hb1, hb1_next;
  logic [1:0]           hb_count, hb_count_next;
  logic [SFD_LEN_W-1:0] byte_count, byte_count_next;

  logic       emit;
  logic [7:0] dec;
  logic       do_dec;

  assign tok_pop  = tok_valid & ~res_full;
  assign res_push = tok_pop & emit;

  always_comb begin
    mode_next       = mode;
    crc_next        = crc;
    hb0_next        = hb0;
    hb1_next        = hb1;
    hb_count_next   = hb_count;
    byte_count_next = byte_count;
    emit            = 1'b0;
    do_dec          = 1'b0;
    dec             = tok.data;
    res             = '{kind: KIND_STATUS, data: 8'h00, status: ST_OK, length: '0};

    unique case (mode) inside
      M_ADDR: begin
        if (tok.is_start) begin
          emit       = 1'b1;
          res.status = ST_START;
        end else if (tok.is_end) begin
          mode_next  = M_IDLE;
          emit       = 1'b1;
          res.status = ST_TRUNC;
        end else if (!tok.is_host) begin
          mode_next  = M_DROP;
          emit       = 1'b1;
          res.status = ST_ADDR;
        end else begin
          crc_next  = crc_step(16'h0000, tok.data);
          mode_next = M_BODY;
        end
      end
      M_BODY: begin
        if (tok.is_start) begin
          emit            = 1'b1;
          res.status      = ST_START;
          res.length      = byte_count;
          mode_next       = M_ADDR;
          crc_next        = '0;
          hb_count_next   = '0;
          byte_count_next = '0;
        end else if (tok.is_end) begin
          mode_next = M_IDLE;
          emit      = 1'b1;
          if (hb_count != 2'd2) begin
            res.status = ST_TRUNC;
          end else begin
            res.status = ({hb0, hb1} == crc) ? ST_OK : ST_CRC;
            res.length = byte_count;
          end
        end else if (tok.is_esc) begin
          mode_next = M_ESC;
        end else begin
          do_dec = 1'b1;
        end
      end
      M_ESC: begin
        mode_next = M_BODY;
        dec       = tok.data ^ ESC_XOR;
        do_dec    = 1'b1;
      end
      M_DROP, M_IDLE: begin
        if (tok.is_start) begin
          mode_next       = M_ADDR;
          crc_next        = '0;
          hb_count_next   = '0;
          byte_count_next = '0;
        end else if (tok.is_end || mode == M_IDLE) begin
          mode_next = M_IDLE;
        end
      end
      default: mode_next = M_IDLE;
    endcase

    // holdback: a decoded byte pushes the oldest held byte out as payload
    if (do_dec) begin
      if (hb_count != 2'd2) begin
        if (hb_count[0]) begin
          hb1_next = dec;
        end else begin
          hb0_next = dec;
        end
        hb_count_next = hb_count + 1'b1;
      end else if (byte_count >= LEN_CAP) begin
        mode_next  = M_DROP;
        emit       = 1'b1;
        res.status = ST_LONG;
        res.length = byte_count;
      end else begin
        hb0_next        = hb1;
        hb1_next        = dec;
        crc_next        = crc_step(crc, hb0);
        byte_count_next = byte_count + 1'b1;
        emit            = 1'b1;
        res.kind        = KIND_DATA;
        res.data        = hb0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      crc        <= '0;
      hb_count   <= '0;
      byte_count <= '0;
    end else if (tok_pop) begin
      mode       <= mode_next;
      crc        <= crc_next;
      hb_count   <= hb_count_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      hb0 <= hb0_next;
      hb1 <= hb1_next;
    end
  end

endmodule

@@ hw/rtl/stuffed_frame_deframer_crc16.sv @@
// top level of the byte-stuffed frame deframer with crc16/kermit check
// depends on sfd_pkg, sfd_class, sfd_fifo, sfd_parse
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------
//   input     push / full          rx_byte
//   result    empty / pop          result_kind, data_byte, frame_status,
//                                  payload_length
//   config    cfg_we               cfg_index, cfg_data
//
// one link byte per cycle sustained while the result side pops; the parser
// consumes a queued byte every cycle in which the result queue has room, and
// the byte-wide crc update plus the unescape step are the longest path in the
// parser; each result passes the byte queue, the parser and the result queue
// rst is synchronous and restores the reset register values, idle hunt mode
// a stalled result side fills the result queue, then the byte queue, then
// raises full; each queue holds QUEUE_DEPTH transactions
module stuffed_frame_deframer_crc16
  import sfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SFD_MAX_PAYLOAD,
  parameter int QUEUE_DEPTH = SFD_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  // link bytes in
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           rx_byte,
  // results out
  output logic                 empty,
  input  logic                 pop,
  output logic                 result_kind,
  output logic [7:0]           data_byte,
  output logic [2:0]           frame_status,
  output logic [SFD_LEN_W-1:0] payload_length
);

  tok_t in_tok;
  tok_t q_tok;
  logic tok_empty;
  logic tok_pop;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  // front: classify each byte against the control codes as it arrives
  sfd_class u_class (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .tok       (in_tok)
  );

  // classified bytes wait here until the parser can take them
  sfd_fifo #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_tok),
    .full    (full),
    .rd_en   (tok_pop),
    .rd_data (q_tok),
    .empty   (tok_empty)
  );

  // back: frame state, holdback, crc and status
  sfd_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .tok       (q_tok),
    .tok_valid (~tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // results queue, the oldest one drives the result ports
  sfd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign result_kind    = res_out.kind;
  assign data_byte      = res_out.data;
  assign frame_status   = res_out.status;
  assign payload_length = res_out.length;

endmodule
